// ----- src/tcdr_pkg.sv -----
// shared types and constants for the terminal cell diff run finder
package tcdr_pkg;

   localparam int unsigned MAX_COLUMNS_DEF = 1024;
   localparam int unsigned MAX_ROWS_DEF    = 1024;

   localparam int unsigned GLYPH_W    = 21;
   localparam int unsigned COLOR_W    = 32;
   localparam int unsigned POS_W      = 10;
   localparam int unsigned SIZE_W     = 11;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 4;

   localparam logic [SIZE_W-1:0]  LINE_WIDTH_RST    = SIZE_W'(80);
   localparam logic [SIZE_W-1:0]  LINE_COUNT_RST    = SIZE_W'(24);
   localparam logic [COLOR_W-1:0] DEFAULT_COLOR_RST = '0;

   typedef enum logic [1:0] {
      CSR_LINE_WIDTH    = 2'd0,
      CSR_LINE_COUNT    = 2'd1,
      CSR_DEFAULT_COLOR = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [GLYPH_W-1:0] old_glyph;
      logic [GLYPH_W-1:0] new_glyph;
      logic [COLOR_W-1:0] old_fore;
      logic [COLOR_W-1:0] new_fore;
      logic [COLOR_W-1:0] old_back;
      logic [COLOR_W-1:0] new_back;
   } req_item_type;

   typedef struct packed {
      logic               change;
      logic [COLOR_W-1:0] color;
      logic               reset;
   } colour_cmd_type;

   typedef struct packed {
      logic               valid;
      logic [COLOR_W-1:0] color;
   } sent_colour_type;

   typedef struct packed {
      logic [POS_W-1:0]   column;
      logic [POS_W-1:0]   row;
      logic [GLYPH_W-1:0] glyph;
      logic               run_start;
      colour_cmd_type     fore;
      colour_cmd_type     back;
   } rsp_item_type;

endpackage

// ----- src/tcdr_req_if.sv -----
// cell pair channel carrying old and new frame cells
interface tcdr_req_if;
   logic                          valid;
   logic                          ready;
   logic [tcdr_pkg::GLYPH_W-1:0]  old_glyph;
   logic [tcdr_pkg::GLYPH_W-1:0]  new_glyph;
   logic [tcdr_pkg::COLOR_W-1:0]  old_fore;
   logic [tcdr_pkg::COLOR_W-1:0]  new_fore;
   logic [tcdr_pkg::COLOR_W-1:0]  old_back;
   logic [tcdr_pkg::COLOR_W-1:0]  new_back;

   modport source (output valid, old_glyph, new_glyph, old_fore, new_fore, old_back,
                   new_back, input ready);
   modport sink (input valid, old_glyph, new_glyph, old_fore, new_fore, old_back,
                 new_back, output ready);
endinterface

// ----- src/tcdr_rsp_if.sv -----
// emitted cell channel with cursor and colour commands
interface tcdr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tcdr_pkg::POS_W-1:0]    column;
   logic [tcdr_pkg::POS_W-1:0]    row;
   logic [tcdr_pkg::GLYPH_W-1:0]  glyph;
   logic                          run_start;
   logic                          fore_change;
   logic [tcdr_pkg::COLOR_W-1:0]  fore_color;
   logic                          fore_reset;
   logic                          back_change;
   logic [tcdr_pkg::COLOR_W-1:0]  back_color;
   logic                          back_reset;

   modport source (output valid, column, row, glyph, run_start, fore_change, fore_color,
                   fore_reset, back_change, back_color, back_reset, input ready);
   modport sink (input valid, column, row, glyph, run_start, fore_change, fore_color,
                 fore_reset, back_change, back_color, back_reset, output ready);
endinterface

// ----- src/tcdr_colour_cmd.sv -----
// colour set or reset command for one plane against the last colour sent
module tcdr_colour_cmd (
   input  logic [tcdr_pkg::COLOR_W-1:0] want,
   input  logic [tcdr_pkg::COLOR_W-1:0] base_colour,
   input  tcdr_pkg::sent_colour_type    sent_cur,
   output tcdr_pkg::colour_cmd_type     cmd,
   output tcdr_pkg::sent_colour_type    sent_next
);

   always_comb begin
      cmd       = '0;
      sent_next = sent_cur;
      if (want == base_colour) begin
         if (sent_cur.valid) begin
            cmd.reset = 1'b1;
            sent_next = '0;
         end
      end else if (!sent_cur.valid || (sent_cur.color != want)) begin
         cmd.change      = 1'b1;
         cmd.color       = want;
         sent_next.valid = 1'b1;
         sent_next.color = want;
      end
   end

endmodule

// ----- src/terminal_cell_diff_runs.sv -----
// terminal cell diff run finder: top level with csr port and cell pipeline
// a cell is registered at acceptance and its result is registered when stage s1 advances
// one cell per cycle unless output stalls; cells that open or extend a run give a beat each
// the run and colour state updates in the single evaluation stage, so cells follow back to back
// reset: synchronous, clears counters, run and sent colour state, and sizes to 80 by 24
module terminal_cell_diff_runs #(
   parameter int unsigned MAX_COLUMNS = tcdr_pkg::MAX_COLUMNS_DEF,
   parameter int unsigned MAX_ROWS    = tcdr_pkg::MAX_ROWS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   tcdr_req_if.sink                          req_chan,
   tcdr_rsp_if.source                        rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tcdr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [tcdr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tcdr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int unsigned CW  = $clog2(MAX_COLUMNS);
   localparam int unsigned RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int unsigned CSW = (CW + 1 > tcdr_pkg::SIZE_W) ? CW + 1 : tcdr_pkg::SIZE_W;
   localparam int unsigned RSW = (RW + 1 > tcdr_pkg::SIZE_W) ? RW + 1 : tcdr_pkg::SIZE_W;
   localparam int unsigned CXW = (CW > tcdr_pkg::POS_W) ? CW : tcdr_pkg::POS_W;
   localparam int unsigned RXW = (RW > tcdr_pkg::POS_W) ? RW : tcdr_pkg::POS_W;

   // csr registers
   logic [tcdr_pkg::SIZE_W-1:0]  line_width_ff;
   logic [tcdr_pkg::SIZE_W-1:0]  line_count_ff;
   logic [tcdr_pkg::COLOR_W-1:0] base_colour_ff;
   logic                         csr_write;
   tcdr_pkg::csr_index_type      csr_index;

   // pipeline registers
   logic                       s1_valid_ff, s1_valid_in;
   tcdr_pkg::req_item_type     s1_item_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   tcdr_pkg::rsp_item_type     rsp_item_ff, rsp_item_in;

   // scan state
   logic [CW-1:0]              col_ff, col_in;
   logic [RW-1:0]              row_ff, row_in;
   logic                       run_open_ff, run_open_in;
   logic [tcdr_pkg::COLOR_W-1:0] run_fore_ff, run_fore_in;
   logic [tcdr_pkg::COLOR_W-1:0] run_back_ff, run_back_in;
   tcdr_pkg::sent_colour_type  sent_fore_ff, sent_fore_in;
   tcdr_pkg::sent_colour_type  sent_back_ff, sent_back_in;

   logic                       out_free, s1_go, req_accept;
   logic                       continue_run, differs, opens, emit;
   logic                       col_wrap, frame_end;
   logic [CSW-1:0]             lw_x, w_eff;
   logic [RSW-1:0]             lc_x, h_eff;
   logic [CXW-1:0]             col_x;
   logic [RXW-1:0]             row_x;
   tcdr_pkg::colour_cmd_type   fore_cmd, back_cmd;
   tcdr_pkg::sent_colour_type  fore_sent_next, back_sent_next;

   // csr port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = tcdr_pkg::csr_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff  <= tcdr_pkg::LINE_WIDTH_RST;
         line_count_ff  <= tcdr_pkg::LINE_COUNT_RST;
         base_colour_ff <= tcdr_pkg::DEFAULT_COLOR_RST;
      end else if (csr_write) begin
         case (csr_index)
            tcdr_pkg::CSR_LINE_WIDTH: begin
               line_width_ff <= csr_pwdata[tcdr_pkg::SIZE_W-1:0];
            end
            tcdr_pkg::CSR_LINE_COUNT: begin
               line_count_ff <= csr_pwdata[tcdr_pkg::SIZE_W-1:0];
            end
            tcdr_pkg::CSR_DEFAULT_COLOR: begin
               base_colour_ff <= csr_pwdata[tcdr_pkg::COLOR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         tcdr_pkg::CSR_LINE_WIDTH:    csr_prdata = tcdr_pkg::CSR_DATA_W'(line_width_ff);
         tcdr_pkg::CSR_LINE_COUNT:    csr_prdata = tcdr_pkg::CSR_DATA_W'(line_count_ff);
         tcdr_pkg::CSR_DEFAULT_COLOR: csr_prdata = tcdr_pkg::CSR_DATA_W'(base_colour_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   // handshake
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_go          = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // clamped frame size
   always_comb begin
      lw_x = CSW'(line_width_ff);
      if (lw_x == '0) begin
         w_eff = CSW'(1);
      end else if (lw_x > CSW'(MAX_COLUMNS)) begin
         w_eff = CSW'(MAX_COLUMNS);
      end else begin
         w_eff = lw_x;
      end
      lc_x = RSW'(line_count_ff);
      if (lc_x == '0) begin
         h_eff = RSW'(1);
      end else if (lc_x > RSW'(MAX_ROWS)) begin
         h_eff = RSW'(MAX_ROWS);
      end else begin
         h_eff = lc_x;
      end
   end

   assign col_wrap  = (CSW'(col_ff) + CSW'(1)) >= w_eff;
   assign frame_end = col_wrap && ((RSW'(row_ff) + RSW'(1)) >= h_eff);

   // run detection
   assign continue_run = run_open_ff && (s1_item_ff.new_fore == run_fore_ff)
                         && (s1_item_ff.new_back == run_back_ff);
   assign differs      = (s1_item_ff.old_glyph != s1_item_ff.new_glyph)
                         || (s1_item_ff.old_fore != s1_item_ff.new_fore)
                         || (s1_item_ff.old_back != s1_item_ff.new_back);
   assign opens        = !continue_run && differs;
   assign emit         = continue_run || opens;

   tcdr_colour_cmd u_fore_cmd (
      .want        (s1_item_ff.new_fore),
      .base_colour (base_colour_ff),
      .sent_cur    (sent_fore_ff),
      .cmd         (fore_cmd),
      .sent_next   (fore_sent_next)
   );

   tcdr_colour_cmd u_back_cmd (
      .want        (s1_item_ff.new_back),
      .base_colour (base_colour_ff),
      .sent_cur    (sent_back_ff),
      .cmd         (back_cmd),
      .sent_next   (back_sent_next)
   );

   assign col_x = CXW'(col_ff);
   assign row_x = RXW'(row_ff);

   always_comb begin
      rsp_item_in           = '0;
      rsp_item_in.column    = col_x[tcdr_pkg::POS_W-1:0];
      rsp_item_in.row       = row_x[tcdr_pkg::POS_W-1:0];
      rsp_item_in.glyph     = s1_item_ff.new_glyph;
      rsp_item_in.run_start = opens;
      if (opens) begin
         rsp_item_in.fore = fore_cmd;
         rsp_item_in.back = back_cmd;
      end
   end

   // next state
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      run_open_in  = run_open_ff;
      run_fore_in  = run_fore_ff;
      run_back_in  = run_back_ff;
      sent_fore_in = sent_fore_ff;
      sent_back_in = sent_back_ff;

      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end

      if (s1_go) begin
         rsp_valid_in = emit;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (s1_go) begin
         run_open_in = emit && !col_wrap;
         if (opens) begin
            run_fore_in  = s1_item_ff.new_fore;
            run_back_in  = s1_item_ff.new_back;
            sent_fore_in = fore_sent_next;
            sent_back_in = back_sent_next;
         end
         if (col_wrap) begin
            col_in = '0;
            if (frame_end) begin
               row_in       = '0;
               sent_fore_in = '0;
               sent_back_in = '0;
            end else begin
               row_in = row_ff + RW'(1);
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         run_open_ff  <= 1'b0;
         run_fore_ff  <= '0;
         run_back_ff  <= '0;
         sent_fore_ff <= '0;
         sent_back_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         run_open_ff  <= run_open_in;
         run_fore_ff  <= run_fore_in;
         run_back_ff  <= run_back_in;
         sent_fore_ff <= sent_fore_in;
         sent_back_ff <= sent_back_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff.old_glyph <= req_chan.old_glyph;
         s1_item_ff.new_glyph <= req_chan.new_glyph;
         s1_item_ff.old_fore  <= req_chan.old_fore;
         s1_item_ff.new_fore  <= req_chan.new_fore;
         s1_item_ff.old_back  <= req_chan.old_back;
         s1_item_ff.new_back  <= req_chan.new_back;
      end
      if (s1_go && emit) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.column      = rsp_item_ff.column;
   assign rsp_chan.row         = rsp_item_ff.row;
   assign rsp_chan.glyph       = rsp_item_ff.glyph;
   assign rsp_chan.run_start   = rsp_item_ff.run_start;
   assign rsp_chan.fore_change = rsp_item_ff.fore.change;
   assign rsp_chan.fore_color  = rsp_item_ff.fore.color;
   assign rsp_chan.fore_reset  = rsp_item_ff.fore.reset;
   assign rsp_chan.back_change = rsp_item_ff.back.change;
   assign rsp_chan.back_color  = rsp_item_ff.back.color;
   assign rsp_chan.back_reset  = rsp_item_ff.back.reset;

endmodule

// ----- src/tcdr_checker.sv -----
// port level checks for the terminal cell diff run finder, with its bind
module tcdr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          run_start,
   input logic                          fore_change,
   input logic [tcdr_pkg::COLOR_W-1:0]  fore_color,
   input logic                          fore_reset,
   input logic                          back_change,
   input logic [tcdr_pkg::COLOR_W-1:0]  back_color,
   input logic                          back_reset
);

   // no beat straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // cells inside a run carry no colour commands
   a_inner_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !run_start |-> !fore_change && !fore_reset && !back_change
                                  && !back_reset && fore_color == '0 && back_color == '0)
      else $error("colour command on a cell inside a run");

   // set and reset exclude each other, colour is zero without a set
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(fore_change && fore_reset) && !(back_change && back_reset)
                    && (fore_change || fore_color == '0) && (back_change || back_color == '0))
      else $error("inconsistent colour command");

endmodule

bind terminal_cell_diff_runs tcdr_checker u_tcdr_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .run_start   (rsp_chan.run_start),
   .fore_change (rsp_chan.fore_change),
   .fore_color  (rsp_chan.fore_color),
   .fore_reset  (rsp_chan.fore_reset),
   .back_change (rsp_chan.back_change),
   .back_color  (rsp_chan.back_color),
   .back_reset  (rsp_chan.back_reset)
);

// ----- tb/tcdr_run_checker.sv -----
// run checker: predicts emitted cells from accepted cell pairs and compares every result beat
module tcdr_run_checker #(
   parameter int unsigned MAX_COLUMNS = tcdr_pkg::MAX_COLUMNS_DEF,
   parameter int unsigned MAX_ROWS    = tcdr_pkg::MAX_ROWS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   tcdr_req_if                             req_mon,
   tcdr_rsp_if                             rsp_mon,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tcdr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tcdr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                            csr_pready,
   output int                              fail_count,
   output int                              pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import tcdr_pkg::*;

   logic [SIZE_W-1:0]  width_reg;
   logic [SIZE_W-1:0]  count_reg;
   logic [COLOR_W-1:0] default_reg;

   int unsigned        col_pos;
   int unsigned        row_pos;
   bit                 run_open;
   logic [COLOR_W-1:0] run_fore;
   logic [COLOR_W-1:0] run_back;
   sent_colour_type    sent_fore;
   sent_colour_type    sent_back;

   rsp_item_type       awaited_cells[$];

   task automatic report(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [COLOR_W-1:0] got,
                              input logic [COLOR_W-1:0] want);
      if (got !== want) begin
         report($sformatf("%s got %0h expected %0h", name, got, want));
      end
   endtask

   function automatic int unsigned clamp_size(input logic [SIZE_W-1:0] v, input int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return 32'(v);
   endfunction

   function automatic colour_cmd_type colour_command(input logic [COLOR_W-1:0] want,
                                                     input sent_colour_type sent);
      colour_cmd_type cmd;
      cmd = '0;
      if (want == default_reg) begin
         cmd.reset = sent.valid;
      end else if (!sent.valid || sent.color != want) begin
         cmd.change = 1'b1;
         cmd.color  = want;
      end
      return cmd;
   endfunction

   function automatic sent_colour_type sent_after(input colour_cmd_type cmd,
                                                  input sent_colour_type sent);
      if (cmd.reset) return '0;
      if (cmd.change) return '{valid: 1'b1, color: cmd.color};
      return sent;
   endfunction

   task automatic forecast_cell(input req_item_type c);
      rsp_item_type e;
      int unsigned  w;
      int unsigned  h;
      w = clamp_size(width_reg, MAX_COLUMNS);
      h = clamp_size(count_reg, MAX_ROWS);
      e = '0;
      e.column = POS_W'(col_pos);
      e.row    = POS_W'(row_pos);
      e.glyph  = c.new_glyph;
      if (run_open && c.new_fore == run_fore && c.new_back == run_back) begin
         awaited_cells.push_back(e);
      end else begin
         run_open = 1'b0;
         if (c.old_glyph != c.new_glyph || c.old_fore != c.new_fore ||
             c.old_back != c.new_back) begin
            run_open    = 1'b1;
            run_fore    = c.new_fore;
            run_back    = c.new_back;
            e.run_start = 1'b1;
            e.fore      = colour_command(c.new_fore, sent_fore);
            sent_fore   = sent_after(e.fore, sent_fore);
            e.back      = colour_command(c.new_back, sent_back);
            sent_back   = sent_after(e.back, sent_back);
            awaited_cells.push_back(e);
         end
      end
      // line end closes the run, frame end forgets the colours sent
      if (col_pos + 1 >= w) begin
         col_pos  = 0;
         run_open = 1'b0;
         if (row_pos + 1 >= h) begin
            row_pos   = 0;
            sent_fore = '0;
            sent_back = '0;
         end else begin
            row_pos++;
         end
      end else begin
         col_pos++;
      end
   endtask

   task automatic check_cell();
      rsp_item_type e;
      if (awaited_cells.size() == 0) begin
         report($sformatf("beat with nothing awaited at column %0d row %0d",
                          rsp_mon.column, rsp_mon.row));
      end else begin
         e = awaited_cells.pop_front();
         check_field("column", COLOR_W'(rsp_mon.column), COLOR_W'(e.column));
         check_field("row", COLOR_W'(rsp_mon.row), COLOR_W'(e.row));
         check_field("glyph", COLOR_W'(rsp_mon.glyph), COLOR_W'(e.glyph));
         check_field("run_start", COLOR_W'(rsp_mon.run_start), COLOR_W'(e.run_start));
         check_field("fore_change", COLOR_W'(rsp_mon.fore_change), COLOR_W'(e.fore.change));
         check_field("fore_color", rsp_mon.fore_color, e.fore.color);
         check_field("fore_reset", COLOR_W'(rsp_mon.fore_reset), COLOR_W'(e.fore.reset));
         check_field("back_change", COLOR_W'(rsp_mon.back_change), COLOR_W'(e.back.change));
         check_field("back_color", rsp_mon.back_color, e.back.color);
         check_field("back_reset", COLOR_W'(rsp_mon.back_reset), COLOR_W'(e.back.reset));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fail_count  = 0;
         width_reg   = LINE_WIDTH_RST;
         count_reg   = LINE_COUNT_RST;
         default_reg = DEFAULT_COLOR_RST;
         col_pos     = 0;
         row_pos     = 0;
         run_open    = 1'b0;
         run_fore    = '0;
         run_back    = '0;
         sent_fore   = '0;
         sent_back   = '0;
         awaited_cells.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[3:2]))
               CSR_LINE_WIDTH:    width_reg   = csr_pwdata[SIZE_W-1:0];
               CSR_LINE_COUNT:    count_reg   = csr_pwdata[SIZE_W-1:0];
               CSR_DEFAULT_COLOR: default_reg = csr_pwdata[COLOR_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            forecast_cell({req_mon.old_glyph, req_mon.new_glyph, req_mon.old_fore,
                           req_mon.new_fore, req_mon.old_back, req_mon.new_back});
         end
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            check_cell();
         end
      end
      pending <= awaited_cells.size();
   end

endmodule

// ----- tb/tb_terminal_cell_diff_runs.sv -----
// testbench top: drives cell pairs and register writes, stalls the output, gives the verdict
module tb_terminal_cell_diff_runs;
   timeunit 1ns;
   timeprecision 1ps;
   import tcdr_pkg::*;

   localparam int unsigned GLYPH_MAX   = 1114111;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int          PHASES      = 16;
   localparam int          PHASE_CELLS = 105;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int                    fail_count;
   int                    pending;
   bit                    hold_off_req;
   int                    tx_calm;
   logic [COLOR_W-1:0]    palette [4];
   logic [COLOR_W-1:0]    line_fore;
   logic [COLOR_W-1:0]    line_back;

   tcdr_req_if req_chan();
   tcdr_rsp_if rsp_chan();

   terminal_cell_diff_runs u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   tcdr_run_checker u_chk (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL");
      $finish;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   function automatic logic [COLOR_W-1:0] pick_colour();
      if ($urandom_range(0, 99) < 85) return palette[$urandom_range(0, 3)];
      return $urandom();
   endfunction

   // output side: random stalls, calm stretches and one long hold-off on request
   initial begin
      int gap;
      int calm;
      bit held;
      gap  = 0;
      calm = 0;
      held = 1'b0;
      rsp_chan.ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_off_req && !held) begin
            held = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_chan.ready <= 1'b1;
         end else if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            gap--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (calm > 0) calm--;
            else if ($urandom_range(0, 99) < 4) calm = $urandom_range(40, 200);
            else gap = gap_len();
         end
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_frame(input int unsigned w, input int unsigned h,
                            input logic [COLOR_W-1:0] dc);
      write_reg(CSR_LINE_WIDTH, w);
      write_reg(CSR_LINE_COUNT, h);
      write_reg(CSR_DEFAULT_COLOR, dc);
      palette[0] = dc;
      palette[1] = $urandom();
      palette[2] = $urandom();
      palette[3] = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      line_fore  = dc;
      line_back  = dc;
   endtask

   task automatic send_cell(input logic [GLYPH_W-1:0] old_g, new_g,
                            input logic [COLOR_W-1:0] old_f, new_f, old_b, new_b);
      int gap;
      if (tx_calm > 0) begin
         tx_calm--;
         gap = 0;
      end else if ($urandom_range(0, 99) < 3) begin
         tx_calm = $urandom_range(40, 200);
         gap = 0;
      end else begin
         gap = gap_len();
      end
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.old_glyph <= old_g;
      req_chan.new_glyph <= new_g;
      req_chan.old_fore  <= old_f;
      req_chan.new_fore  <= new_f;
      req_chan.old_back  <= old_b;
      req_chan.new_back  <= new_b;
      req_chan.valid     <= 1'b1;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   // mostly frame-like content with runs of shared colours, some pure noise
   task automatic random_cell();
      logic [GLYPH_W-1:0] old_g;
      logic [GLYPH_W-1:0] new_g;
      logic [COLOR_W-1:0] old_f;
      logic [COLOR_W-1:0] new_f;
      logic [COLOR_W-1:0] old_b;
      logic [COLOR_W-1:0] new_b;
      int                 kind;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         old_g = GLYPH_W'($urandom_range(0, GLYPH_MAX));
         new_g = GLYPH_W'($urandom_range(0, GLYPH_MAX));
         old_f = $urandom();
         new_f = $urandom();
         old_b = $urandom();
         new_b = $urandom();
      end else begin
         if ($urandom_range(0, 9) == 0) line_fore = pick_colour();
         if ($urandom_range(0, 9) == 0) line_back = pick_colour();
         if ($urandom_range(0, 4) == 0) new_g = GLYPH_W'($urandom_range(0, GLYPH_MAX));
         else new_g = GLYPH_W'($urandom_range(32, 126));
         old_g = new_g;
         new_f = line_fore;
         old_f = new_f;
         new_b = line_back;
         old_b = new_b;
         kind  = $urandom_range(0, 99);
         if (kind >= 88) old_b = pick_colour();
         else if (kind >= 75) old_f = pick_colour();
         else if (kind >= 50) old_g = GLYPH_W'($urandom_range(0, GLYPH_MAX));
      end
      send_cell(old_g, new_g, old_f, new_f, old_b, new_b);
   endtask

   task automatic drain_cells();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.old_glyph = '0;
      req_chan.new_glyph = '0;
      req_chan.old_fore  = '0;
      req_chan.new_fore  = '0;
      req_chan.old_back  = '0;
      req_chan.new_back  = '0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      hold_off_req       = 1'b0;
      tx_calm            = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // four by two frame, default colour black
      set_frame(4, 2, 32'h0);
      send_cell(21'd0, 21'd1114111, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0);
      send_cell(21'd5, 21'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
      send_cell(21'd7, 21'd7, 32'h0, 32'h00FF_00FF, 32'h0, 32'h0);
      send_cell(21'd9, 21'd9, 32'h0, 32'h0, 32'h0, 32'h0);
      send_cell(21'd1, 21'd2, 32'h0, 32'h0, 32'h0, 32'h0);
      send_cell(21'd3, 21'd4, 32'h0, 32'h0, 32'h0, 32'h1234_5678);
      send_cell(21'd8, 21'd8, 32'h0, 32'h0, 32'h1234_5678, 32'h1234_5678);
      send_cell(21'd6, 21'd6, 32'h0, 32'h0, 32'h1234_5678, 32'h1234_5678);
      // second frame: run closed by line end, sent colours forgotten
      send_cell(21'd6, 21'd6, 32'h0, 32'h0, 32'h1234_5678, 32'h1234_5678);
      send_cell(21'd0, 21'd1, 32'h0, 32'h0, 32'h1234_5678, 32'h1234_5678);
      send_cell(21'd2, 21'd2, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
      send_cell(21'd2, 21'd3, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_cell(21'd1114111, 21'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF);
      send_cell(21'd0, 21'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      send_cell(21'd0, 21'd0, 32'h0, 32'h0, 32'h0, 32'h0);
      send_cell(21'd0, 21'd0, 32'h0, 32'h0, 32'h0, 32'h0);
      drain_cells();

      // one cell frames with white as default
      set_frame(1, 1, 32'hFFFF_FFFF);
      send_cell(21'd0, 21'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
      send_cell(21'd0, 21'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
      send_cell(21'd1114111, 21'd1114111, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
      drain_cells();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       set_frame(1, 1, $urandom());
            1:       set_frame(1024, 1024, 32'h0);
            2:       set_frame(0, 0, 32'hFFFF_FFFF);
            3:       set_frame(2047, 2047, $urandom());
            4:       set_frame(2047, 2, 32'h0);
            5:       set_frame(3, 0, 32'hFFFF_FFFF);
            default: set_frame($urandom_range(1, 12), $urandom_range(1, 5),
                               $urandom_range(0, 2) == 0 ? 32'h0 : $urandom());
         endcase
         if (p == 6) hold_off_req = 1'b1;
         repeat (PHASE_CELLS) random_cell();
         drain_cells();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
